// ----- design/bgad_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the bus glue address decoder.
// No dependencies; every other file imports this package.
package bgad_pkg;

   localparam int MAP_PAGES  = 256;
   localparam int PAGE_W     = $clog2(MAP_PAGES);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // result target codes
   typedef logic [3:0] target_type;
   localparam target_type TGT_NONE       = 4'd0;
   localparam target_type TGT_RAM        = 4'd1;
   localparam target_type TGT_ROM        = 4'd2;
   localparam target_type TGT_OPEN_BUS   = 4'd3;
   localparam target_type TGT_IGNORED_IO = 4'd4;
   localparam target_type TGT_VIDEO      = 4'd5;
   localparam target_type TGT_DMA        = 4'd6;
   localparam target_type TGT_PSG_SELECT = 4'd7;
   localparam target_type TGT_PSG_DATA   = 4'd8;
   localparam target_type TGT_MFP        = 4'd9;
   localparam target_type TGT_KBD_ACIA   = 4'd10;
   localparam target_type TGT_MIDI_ACIA  = 4'd11;
   localparam target_type TGT_AUTOVECTOR = 4'd12;
   localparam target_type TGT_MFP_IACK   = 4'd13;

   typedef enum logic [2:0] {
      PG_MOSTLY,
      PG_RAM,
      PG_FLOAT,
      PG_ROM,
      PG_CART,
      PG_IO,
      PG_UNASSIGNED
   } page_kind_type;

   // register indexes (byte address bit 2)
   localparam logic REG_RAM_PAGES  = 1'b0;
   localparam logic REG_LATE_ROM   = 1'b1;
   localparam logic [6:0] RAM_PAGES_RESET = 7'd8;

   // bus codes
   localparam logic [1:0] STROBE_NULL = 2'd0;
   localparam logic [1:0] DW_NONE     = 2'd0;
   localparam logic [1:0] DW_BYTE     = 2'd1;
   localparam logic [2:0] IACK_MFP_LEVEL = 3'd6;

   // processor interrupt levels
   localparam logic [2:0] IRQ_LVL_MFP   = 3'd6;
   localparam logic [2:0] IRQ_LVL_VSYNC = 3'd4;
   localparam logic [2:0] IRQ_LVL_HSYNC = 3'd2;
   localparam logic [2:0] IRQ_LVL_NONE  = 3'd0;

   // memory map
   localparam logic [PAGE_W-1:0] PAGE_ZERO      = 8'h00;
   localparam logic [PAGE_W-1:0] PAGE_IO        = 8'hff;
   localparam logic [PAGE_W-1:0] PAGE_CART_LO   = 8'hfa;
   localparam logic [PAGE_W-1:0] PAGE_CART_HI   = 8'hfb;
   localparam logic [PAGE_W-1:0] PAGE_ROM_EARLY = 8'hfc;
   localparam logic [PAGE_W-1:0] PAGE_ROM_LATE  = 8'he0;
   localparam logic [PAGE_W-1:0] PAGE_ROM_LATE_END = 8'he4;
   localparam logic [PAGE_W-1:0] PAGE_FLOAT_END = 8'h40;

   localparam logic [23:0] SHIFTER_MODE_ADDR = 24'hff8260;
   localparam logic [23:0] LOW_MEM_LIMIT     = 24'h000800;
   localparam logic [23:0] ROM_BASE_EARLY    = 24'hfc0000;
   localparam logic [23:0] ROM_BASE_LATE     = 24'he00000;
   localparam logic [23:0] BOOT_ROM_BYTES    = 24'h000008;
   localparam logic [15:0] REG_WORD_MASK     = 16'hfffe;
   localparam logic [15:0] OPEN_BUS_WORD     = 16'hffff;
   localparam logic [15:0] OPEN_BUS_BYTE     = 16'h00ff;

   // I/O register windows (word aligned)
   localparam logic [15:0] IO_VIDEO_LO = 16'h8200;
   localparam logic [15:0] IO_VIDEO_HI = 16'h8262;
   localparam logic [15:0] IO_DMA_LO   = 16'h8604;
   localparam logic [15:0] IO_DMA_HI   = 16'h860c;
   localparam logic [15:0] IO_PSG_LO   = 16'h8800;
   localparam logic [15:0] IO_PSG_HI   = 16'h88fe;
   localparam logic [15:0] IO_MFP_LO   = 16'hfa00;
   localparam logic [15:0] IO_MFP_HI   = 16'hfa3e;
   localparam logic [15:0] IO_ACIA_LO  = 16'hfc00;
   localparam logic [15:0] IO_ACIA_HI  = 16'hfc06;

   localparam logic [2:0] ALIGN_PHASE = 3'd4;
   localparam logic [2:0] PSG_WAIT    = 3'd2;

   typedef struct packed {
      logic        action;
      logic [23:0] address;
      logic        supervisor;
      logic [1:0]  strobe_req;
      logic        acknowledge;
      logic        is_read;
      logic [1:0]  data_width;
      logic [7:0]  cycle_length;
      logic        hsync;
      logic        vsync;
      logic        mfp_irq;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  target;
      logic [23:0] offset;
      logic        bus_error;
      logic        peripheral_address;
      logic [2:0]  dtack_delay;
      logic [15:0] open_bus_value;
      logic [2:0]  irq_level;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0] ram_pages;
      logic       late_rom_layout;
   } cfg_type;

   typedef struct packed {
      page_kind_type kind;
      target_type    io_target;
      logic          in_ram;
      logic          shifter_mode;
      logic          low_mem;
   } page_decode_type;

endpackage

// ----- design/bgad_channels.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for bus items and their results.
// Depends on bgad_pkg for the payload types.
interface bgad_req_if;
   import bgad_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bgad_rsp_if;
   import bgad_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- design/bgad_csr.sv -----
`timescale 1ns / 1ps
// APB-style register block: installed RAM pages and ROM layout select.
// Depends on bgad_pkg.
module bgad_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bgad_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bgad_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bgad_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output bgad_pkg::cfg_type                cfg
);
   import bgad_pkg::*;

   logic [6:0] ram_pages_ff;
   logic       late_rom_ff;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_pages_ff <= RAM_PAGES_RESET;
         late_rom_ff  <= 1'b0;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_RAM_PAGES: ram_pages_ff <= pwdata[6:0];
            REG_LATE_ROM:  late_rom_ff  <= pwdata[0];
            default:       ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_RAM_PAGES: prdata = {{(CSR_DATA_W-7){1'b0}}, ram_pages_ff};
         REG_LATE_ROM:  prdata = {{(CSR_DATA_W-1){1'b0}}, late_rom_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg = '{ram_pages: ram_pages_ff, late_rom_layout: late_rom_ff};

endmodule

// ----- design/bgad_page_decode.sv -----
`timescale 1ns / 1ps
// Page classifier and I/O register window decode for one bus address.
// Depends on bgad_pkg; pure combinational logic.
module bgad_page_decode (
   input  logic [23:0]               address,
   input  bgad_pkg::cfg_type         cfg,
   output bgad_pkg::page_decode_type dec
);
   import bgad_pkg::*;

   logic [PAGE_W-1:0] page;
   logic [15:0]       reg_word;
   logic              below_ram;
   logic              rom_page;
   page_kind_type     page_kind;
   target_type        io_tgt;

   assign page      = address[23:24-PAGE_W];
   assign reg_word  = address[15:0] & REG_WORD_MASK;
   assign below_ram = page < {1'b0, cfg.ram_pages};
   assign rom_page  = cfg.late_rom_layout ?
                      (page >= PAGE_ROM_LATE && page < PAGE_ROM_LATE_END) :
                      (page >= PAGE_ROM_EARLY && page < PAGE_IO);

   always_comb begin
      if (page == PAGE_IO)                                page_kind = PG_IO;
      else if (page == PAGE_CART_LO || page == PAGE_CART_HI) page_kind = PG_CART;
      else if (rom_page)                                  page_kind = PG_ROM;
      else if (page == PAGE_ZERO)                         page_kind = PG_MOSTLY;
      else if (below_ram)                                 page_kind = PG_RAM;
      else if (page < PAGE_FLOAT_END)                     page_kind = PG_FLOAT;
      else                                                page_kind = PG_UNASSIGNED;
   end

   always_comb begin
      if (reg_word >= IO_VIDEO_LO && reg_word <= IO_VIDEO_HI)
         io_tgt = TGT_VIDEO;
      else if (reg_word >= IO_DMA_LO && reg_word <= IO_DMA_HI)
         io_tgt = TGT_DMA;
      else if (reg_word >= IO_PSG_LO && reg_word <= IO_PSG_HI)
         io_tgt = address[1] ? TGT_PSG_DATA : TGT_PSG_SELECT;
      else if (reg_word >= IO_MFP_LO && reg_word <= IO_MFP_HI)
         io_tgt = TGT_MFP;
      else if (reg_word >= IO_ACIA_LO && reg_word <= IO_ACIA_HI)
         io_tgt = address[2] ? TGT_MIDI_ACIA : TGT_KBD_ACIA;
      else
         io_tgt = TGT_IGNORED_IO;
   end

   assign dec = '{kind:         page_kind,
                  io_target:    io_tgt,
                  in_ram:       below_ram,
                  shifter_mode: (address == SHIFTER_MODE_ADDR),
                  low_mem:      (address < LOW_MEM_LIMIT)};

endmodule

// ----- design/bus_glue_address_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the bus glue: input register, decode, state update, result register.
// Depends on bgad_pkg, bgad_channels, bgad_csr and bgad_page_decode.
//
//   channel | dir | handshake        | carries
//   req_ch  | in  | valid/ready      | bus cycle or interrupt line update
//   rsp_ch  | out | valid/ready      | decode result and interrupt level
//   csr_*   | in  | APB psel/penable | ram_pages, late_rom_layout
//
// One item per clock sustained while results are taken; an accepted item waits in the
// input register, is decoded out of it into the result register and is offered from there.
// The phase counter and video interrupt state update in the cycle an
// item moves into the result register.
// A stalled result holds in place; the input register still takes one more item.
// Synchronous reset clears the phase, pending interrupts and sync history, and
// loads 8 RAM pages with the early ROM layout.
module bus_glue_address_decoder (
   input  logic                            clock,
   input  logic                            reset,
   bgad_req_if.sink                        req_ch,
   bgad_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bgad_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bgad_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bgad_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import bgad_pkg::*;

   cfg_type         cfg;
   page_decode_type dec;

   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   logic [2:0] bus_phase_ff, bus_phase_in;
   logic [1:0] pending_ff, pending_in;
   logic       last_hsync_ff, last_hsync_in;
   logic       last_vsync_ff, last_vsync_in;

   logic advance;
   logic req_take;

   bgad_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   bgad_page_decode u_decode (
      .address (s1_item_ff.address),
      .cfg     (cfg),
      .dec     (dec)
   );

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      logic [2:0]  phase_v;
      logic [1:0]  pend_v;
      logic [2:0]  delay_v;
      logic        ds;
      logic        fault;
      logic [2:0]  lvl;
      req_item_type it;

      it      = s1_item_ff;
      phase_v = bus_phase_ff;
      pend_v  = pending_ff;
      delay_v = 3'd0;
      ds      = it.data_width != DW_NONE;
      fault   = 1'b0;
      lvl     = it.address[3:1];
      last_hsync_in = last_hsync_ff;
      last_vsync_in = last_vsync_ff;
      rsp_item_in   = '0;

      if (it.action) begin
         pend_v[0] = pend_v[0] | (last_hsync_ff & ~it.hsync);
         pend_v[1] = pend_v[1] | (last_vsync_ff & ~it.vsync);
         last_hsync_in = it.hsync;
         last_vsync_in = it.vsync;
      end else begin
         phase_v = bus_phase_ff + it.cycle_length[2:0];
         if (it.strobe_req != STROBE_NULL) begin
            if (it.acknowledge) begin
               if (lvl != IACK_MFP_LEVEL) begin
                  // clear the acknowledged video level, then look for new edges
                  if (lvl[1]) pend_v[0] = 1'b0;
                  if (lvl[2]) pend_v[1] = 1'b0;
                  pend_v[0] = pend_v[0] | (last_hsync_ff & ~it.hsync);
                  pend_v[1] = pend_v[1] | (last_vsync_ff & ~it.vsync);
                  last_hsync_in = it.hsync;
                  last_vsync_in = it.vsync;
                  rsp_item_in.peripheral_address = 1'b1;
                  rsp_item_in.target = TGT_AUTOVECTOR;
               end else begin
                  rsp_item_in.target = TGT_MFP_IACK;
                  rsp_item_in.bus_error = (it.data_width == DW_BYTE) && !it.mfp_irq;
               end
            end else begin
               if (it.strobe_req[0]) begin
                  if (dec.kind == PG_UNASSIGNED ||
                      (!it.supervisor && (dec.low_mem || dec.kind == PG_IO))) begin
                     fault = 1'b1;
                  end else if (dec.in_ram || dec.shifter_mode) begin
                     // wait out the rest of the memory slot
                     if (phase_v < ALIGN_PHASE) begin
                        delay_v = ALIGN_PHASE - phase_v;
                        phase_v = ALIGN_PHASE;
                     end
                  end
               end
               rsp_item_in.bus_error = fault;
               if (!fault) begin
                  case (dec.kind)
                     PG_MOSTLY: begin
                        rsp_item_in.target = (it.address < BOOT_ROM_BYTES) ?
                                             TGT_ROM : TGT_RAM;
                        rsp_item_in.offset = it.address;
                     end
                     PG_RAM: begin
                        rsp_item_in.target = TGT_RAM;
                        rsp_item_in.offset = it.address;
                     end
                     PG_ROM: begin
                        rsp_item_in.target = TGT_ROM;
                        rsp_item_in.offset = it.address -
                           (cfg.late_rom_layout ? ROM_BASE_LATE : ROM_BASE_EARLY);
                     end
                     PG_IO: begin
                        rsp_item_in.target = dec.io_target;
                        rsp_item_in.offset = {1'b0, it.address[23:1]};
                        if (dec.io_target == TGT_KBD_ACIA ||
                            dec.io_target == TGT_MIDI_ACIA)
                           rsp_item_in.peripheral_address = !ds;
                        if (dec.io_target == TGT_IGNORED_IO) begin
                           delay_v = 3'd0;
                        end else if (ds) begin
                           if (dec.io_target == TGT_PSG_SELECT ||
                               dec.io_target == TGT_PSG_DATA) begin
                              phase_v = phase_v + PSG_WAIT;
                              delay_v = delay_v + PSG_WAIT;
                           end else begin
                              delay_v = 3'd0;
                           end
                        end
                     end
                     default: begin
                        rsp_item_in.target = TGT_OPEN_BUS;
                        if (it.is_read && ds)
                           rsp_item_in.open_bus_value = (it.data_width == DW_BYTE) ?
                                                        OPEN_BUS_BYTE : OPEN_BUS_WORD;
                     end
                  endcase
                  rsp_item_in.dtack_delay = delay_v;
               end
            end
         end
      end

      if (it.mfp_irq)     rsp_item_in.irq_level = IRQ_LVL_MFP;
      else if (pend_v[1]) rsp_item_in.irq_level = IRQ_LVL_VSYNC;
      else if (pend_v[0]) rsp_item_in.irq_level = IRQ_LVL_HSYNC;
      else                rsp_item_in.irq_level = IRQ_LVL_NONE;

      bus_phase_in = phase_v;
      pending_in   = pend_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bus_phase_ff  <= 3'd0;
         pending_ff    <= 2'd0;
         last_hsync_ff <= 1'b0;
         last_vsync_ff <= 1'b0;
      end else begin
         if (req_ch.ready) s1_valid_ff <= req_ch.valid;
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               bus_phase_ff  <= bus_phase_in;
               pending_ff    <= pending_in;
               last_hsync_ff <= last_hsync_in;
               last_vsync_ff <= last_vsync_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_item_ff <= req_ch.payload;
      if (advance && s1_valid_ff) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_item_ff;

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |=> rsp_ch.valid && $stable(rsp_ch.payload))
      else $error("result item changed while stalled");

   a_req_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ch.ready)
      else $error("input not ready with an empty input register");

   a_berr_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.payload.bus_error |->
         (rsp_ch.payload.target == TGT_NONE || rsp_ch.payload.target == TGT_MFP_IACK) &&
         rsp_ch.payload.offset == 24'd0 && rsp_ch.payload.dtack_delay == 3'd0)
      else $error("bus error result carries a target, offset or delay");

   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.payload.dtack_delay <= 3'd6)
      else $error("dtack delay out of range");
`endif

endmodule
